// File: hw/rtl/cip8_pkg.sv
`timescale 1ns / 1ps

package cip8_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned ROWS = 8;

	localparam logic [1:0] MODE_DC   = 2'd0;
	localparam logic [1:0] MODE_VERT = 2'd1;
	localparam logic [1:0] MODE_HORZ = 2'd2;
	localparam logic [1:0] MODE_TM   = 2'd3;

	localparam logic [7:0] DC_NONE = 8'd128;

	// Work kinds after classification. DC and vertical both repeat one row.
	typedef enum logic [1:0] {
		KIND_COPY,
		KIND_HORZ,
		KIND_TM
	} kind_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        up_ok;
		logic        left_ok;
		logic [63:0] u_above;
		logic [63:0] v_above;
		logic [63:0] u_left;
		logic [63:0] v_left;
		logic [7:0]  u_corner;
		logic [7:0]  v_corner;
	} req_t;

	typedef struct packed {
		logic [63:0] u_row;
		logic [63:0] v_row;
		logic [2:0]  row_index;
		logic        last_row;
	} row_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] u_above;
		logic [63:0] v_above;
		logic [63:0] u_left;
		logic [63:0] v_left;
		logic [7:0]  u_corner;
		logic [7:0]  v_corner;
	} job_t;

endpackage

// File: hw/rtl/cip8_front.sv
`timescale 1ns / 1ps

module cip8_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  cip8_pkg::req_t  req_data,
	output logic            job_valid,
	input  logic            job_ready,
	output cip8_pkg::job_t  job
);

	logic           valid_s1;
	cip8_pkg::job_t job_s1;
	cip8_pkg::job_t job_next;
	logic [7:0]     u_dc;
	logic [7:0]     v_dc;

	function automatic logic [10:0] byte_sum(input logic [63:0] w);
		logic [10:0] s;
		s = '0;
		for (int k = 0; k < 8; k++) begin
			s = s + 11'(w[k*8 +: 8]);
		end
		return s;
	endfunction

	function automatic logic [7:0] dc_mean(input logic [63:0] above, input logic [63:0] left,
			input logic up, input logic lf);
		logic [11:0] sa;
		logic [11:0] sl;
		logic [11:0] both;
		logic [7:0]  m;
		sa = 12'(byte_sum(above));
		sl = 12'(byte_sum(left));
		both = sa + sl + 12'd8;
		case ({up, lf})
			2'b11:   m = both[11:4];
			2'b10:   m = 8'((sa + 12'd4) >> 3);
			2'b01:   m = 8'((sl + 12'd4) >> 3);
			default: m = cip8_pkg::DC_NONE;
		endcase
		return m;
	endfunction

	always_comb begin
		u_dc = dc_mean(req_data.u_above, req_data.u_left, req_data.up_ok, req_data.left_ok);
		v_dc = dc_mean(req_data.v_above, req_data.v_left, req_data.up_ok, req_data.left_ok);
		job_next.u_above  = req_data.u_above;
		job_next.v_above  = req_data.v_above;
		job_next.u_left   = req_data.u_left;
		job_next.v_left   = req_data.v_left;
		job_next.u_corner = req_data.u_corner;
		job_next.v_corner = req_data.v_corner;
		case (req_data.mode)
			cip8_pkg::MODE_DC: begin
				// DC becomes a repeated row filled with the mean.
				job_next.kind    = cip8_pkg::KIND_COPY;
				job_next.u_above = {8{u_dc}};
				job_next.v_above = {8{v_dc}};
			end
			cip8_pkg::MODE_VERT: job_next.kind = cip8_pkg::KIND_COPY;
			cip8_pkg::MODE_HORZ: job_next.kind = cip8_pkg::KIND_HORZ;
			default:             job_next.kind = cip8_pkg::KIND_TM;
		endcase
	end

	assign req_ready = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			job_s1 <= job_next;
		end
	end

endmodule

// File: hw/rtl/cip8_queue.sv
`timescale 1ns / 1ps

module cip8_queue #(
	parameter int unsigned DEPTH = cip8_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  cip8_pkg::job_t  push_job,
	output logic            pop_valid,
	input  logic            pop_ready,
	output cip8_pkg::job_t  pop_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cip8_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: hw/rtl/cip8_back.sv
`timescale 1ns / 1ps

module cip8_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  cip8_pkg::job_t  job,
	output logic            row_valid,
	input  logic            row_ready,
	output cip8_pkg::row_t  row_data
);

	localparam logic [2:0] LAST_ROW = 3'(cip8_pkg::ROWS - 1);

	cip8_pkg::job_t job_q;
	logic           busy_q;
	logic [2:0]     row_q;
	logic           out_valid_q;
	cip8_pkg::row_t out_q;
	logic           advance;
	logic           finishing;
	cip8_pkg::row_t row_next;

	function automatic logic [63:0] tm_row(input logic [63:0] above, input logic [7:0] left,
			input logic [7:0] corner);
		logic [63:0]       r;
		logic signed [9:0] p;
		r = '0;
		for (int c = 0; c < 8; c++) begin
			p = signed'({2'b00, above[c*8 +: 8]}) + signed'({2'b00, left})
				- signed'({2'b00, corner});
			if (p < 0) begin
				r[c*8 +: 8] = 8'd0;
			end else if (p > 10'sd255) begin
				r[c*8 +: 8] = 8'd255;
			end else begin
				r[c*8 +: 8] = p[7:0];
			end
		end
		return r;
	endfunction

	always_comb begin
		row_next.row_index = row_q;
		row_next.last_row  = (row_q == LAST_ROW);
		case (job_q.kind)
			cip8_pkg::KIND_COPY: begin
				row_next.u_row = job_q.u_above;
				row_next.v_row = job_q.v_above;
			end
			cip8_pkg::KIND_HORZ: begin
				row_next.u_row = {8{job_q.u_left[row_q*8 +: 8]}};
				row_next.v_row = {8{job_q.v_left[row_q*8 +: 8]}};
			end
			default: begin
				row_next.u_row = tm_row(job_q.u_above, job_q.u_left[row_q*8 +: 8],
					job_q.u_corner);
				row_next.v_row = tm_row(job_q.v_above, job_q.v_left[row_q*8 +: 8],
					job_q.v_corner);
			end
		endcase
	end

	// The output register takes a row whenever it is empty or being drained.
	assign advance   = !out_valid_q || row_ready;
	assign finishing = busy_q && advance && (row_q == LAST_ROW);
	assign job_ready = !busy_q || finishing;
	assign row_valid = out_valid_q;
	assign row_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (job_valid && job_ready) begin
				busy_q <= 1'b1;
				row_q  <= '0;
			end else if (finishing) begin
				busy_q <= 1'b0;
			end else if (busy_q && advance) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job;
		end
		if (busy_q && advance) begin
			out_q <= row_next;
		end
	end

endmodule

// File: hw/rtl/chroma_intra_predictor_8x8.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload                 Unit
// request   req_valid/req_ready    req_data  (req_t)       one 8x8 U and V block pair
// result    row_valid/row_ready    row_data  (row_t)       one row, eight per request
//
// A request is classified (DC mean worked out) and registered in the front stage,
// then waits in a short queue until the row sequencer takes it. The sequencer emits
// one row per cycle unless the result side stalls, and blocks follow without a gap.
// On the way out a job passes the queue, the sequencer and its output register.
// Reset clears all valid flags, queue pointers and the row counter.
// A stall on the result side holds the output register; requests keep being
// accepted until the queue and front stage are full.

module chroma_intra_predictor_8x8 #(
	parameter int unsigned QUEUE_DEPTH = cip8_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  cip8_pkg::req_t  req_data,
	output logic            row_valid,
	input  logic            row_ready,
	output cip8_pkg::row_t  row_data
);

	logic           front_valid;
	logic           front_ready;
	cip8_pkg::job_t front_job;
	logic           back_valid;
	logic           back_ready;
	cip8_pkg::job_t back_job;

	cip8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.job       (front_job)
	);

	cip8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_job    (back_job)
	);

	cip8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.job       (back_job),
		.row_valid (row_valid),
		.row_ready (row_ready),
		.row_data  (row_data)
	);

endmodule

// File: dv/chroma_intra_predictor_8x8_tb.sv
`timescale 1ns / 1ps

module chroma_intra_predictor_8x8_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLDOFF = 150;
	localparam int RANDOM_BLOCKS = 264;
	localparam int TAIL_CYCLES = 16;

	typedef struct {
		cip8_pkg::req_t req;
		bit             wait_drain;
	} block_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	cip8_pkg::req_t req_data = '0;
	logic row_valid;
	logic row_ready = 1'b0;
	cip8_pkg::row_t row_data;

	block_item_t block_requests[$];
	cip8_pkg::row_t predicted_rows[$];
	cip8_pkg::row_t want_row;

	int total_blocks = 0;
	int blocks_accepted = 0;
	int rows_checked = 0;
	int errors = 0;
	int mode_hits[4] = '{0, 0, 0, 0};

	bit req_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int holdoff_left = 0;
	bit long_holdoff_done = 1'b0;
	logic [15:0] ready_cycle = '0;

	chroma_intra_predictor_8x8 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.row_valid(row_valid),
		.row_ready(row_ready),
		.row_data(row_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Rounded mean of the available neighbors, 128 when neither side is there.
	function automatic logic [7:0] dc_mean(input logic [63:0] above, input logic [63:0] left,
			input logic up, input logic lf);
		logic [11:0] sum;
		sum = '0;
		if (!up && !lf)
			return cip8_pkg::DC_NONE;
		for (int c = 0; c < 8; c++) begin
			if (up)
				sum += above[c*8 +: 8];
			if (lf)
				sum += left[c*8 +: 8];
		end
		if (up && lf)
			return 8'((sum + 12'd8) >> 4);
		return 8'((sum + 12'd4) >> 3);
	endfunction

	function automatic logic [63:0] tm_row(input logic [63:0] above, input logic [7:0] left,
			input logic [7:0] corner);
		logic [63:0] row;
		int p;
		row = '0;
		for (int c = 0; c < 8; c++) begin
			p = int'(above[c*8 +: 8]) + int'(left) - int'(corner);
			if (p < 0)
				p = 0;
			if (p > 255)
				p = 255;
			row[c*8 +: 8] = 8'(p);
		end
		return row;
	endfunction

	function automatic void predict_block(input cip8_pkg::req_t rq);
		logic [7:0] u_dc;
		logic [7:0] v_dc;
		cip8_pkg::row_t r;
		u_dc = dc_mean(rq.u_above, rq.u_left, rq.up_ok, rq.left_ok);
		v_dc = dc_mean(rq.v_above, rq.v_left, rq.up_ok, rq.left_ok);
		for (int i = 0; i < cip8_pkg::ROWS; i++) begin
			case (rq.mode)
				cip8_pkg::MODE_DC: begin
					r.u_row = {8{u_dc}};
					r.v_row = {8{v_dc}};
				end
				cip8_pkg::MODE_VERT: begin
					r.u_row = rq.u_above;
					r.v_row = rq.v_above;
				end
				cip8_pkg::MODE_HORZ: begin
					r.u_row = {8{rq.u_left[i*8 +: 8]}};
					r.v_row = {8{rq.v_left[i*8 +: 8]}};
				end
				default: begin
					r.u_row = tm_row(rq.u_above, rq.u_left[i*8 +: 8], rq.u_corner);
					r.v_row = tm_row(rq.v_above, rq.v_left[i*8 +: 8], rq.v_corner);
				end
			endcase
			r.row_index = 3'(i);
			r.last_row = (i == cip8_pkg::ROWS - 1);
			predicted_rows.push_back(r);
		end
	endfunction

	function automatic cip8_pkg::req_t make_req(input logic [1:0] mode, input logic up,
			input logic lf, input logic [63:0] ua, input logic [63:0] va, input logic [63:0] ul,
			input logic [63:0] vl, input logic [7:0] uc, input logic [7:0] vc);
		cip8_pkg::req_t rq;
		rq.mode = mode;
		rq.up_ok = up;
		rq.left_ok = lf;
		rq.u_above = ua;
		rq.v_above = va;
		rq.u_left = ul;
		rq.v_left = vl;
		rq.u_corner = uc;
		rq.v_corner = vc;
		return rq;
	endfunction

	// Samples lean toward the ends of the range so that TrueMotion clamps often.
	function automatic logic [7:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_samples();
		logic [63:0] w;
		case ($urandom_range(0, 5))
			0: w = {$urandom, $urandom};
			1: for (int c = 0; c < 8; c++) w[c*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			2: w = {8{rand_sample()}};
			default: for (int c = 0; c < 8; c++) w[c*8 +: 8] = rand_sample();
		endcase
		return w;
	endfunction

	task automatic add_block(input cip8_pkg::req_t rq, input bit wait_drain);
		block_item_t item;
		item.req = rq;
		item.wait_drain = wait_drain;
		block_requests.push_back(item);
		total_blocks++;
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Request driver: bursts of back-to-back transactions separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_taken) begin
			// The offered request has not been taken yet, so it stays put.
		end else begin
			req_taken = 1'b0;
			if (block_requests.size() == 0 ||
					(block_requests[0].wait_drain && predicted_rows.size() != 0)) begin
				req_valid <= 1'b0;
			end else if (gap_left != 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else begin
				req_valid <= 1'b1;
				req_data <= block_requests[0].req;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			predict_block(req_data);
			mode_hits[req_data.mode]++;
			blocks_accepted++;
			void'(block_requests.pop_front());
			req_taken = 1'b1;
		end
	end

	// Row receiver: the stall pattern steps through four phases set by a free-running counter, with occasional hold-offs.
	always @(negedge clk) begin
		ready_cycle <= ready_cycle + 16'd1;
		if (!arst_n) begin
			row_ready <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left--;
			row_ready <= 1'b0;
		end else if (!long_holdoff_done && blocks_accepted >= 30) begin
			long_holdoff_done = 1'b1;
			holdoff_left = LONG_HOLDOFF - 1;
			row_ready <= 1'b0;
		end else if ($urandom_range(0, 299) == 0) begin
			holdoff_left = $urandom_range(10, 40);
			row_ready <= 1'b0;
		end else begin
			case (ready_cycle[7:6])
				2'd0: row_ready <= 1'b1;
				2'd1: row_ready <= 1'($urandom_range(0, 1));
				2'd2: row_ready <= ($urandom_range(0, 3) == 0);
				default: row_ready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && row_valid && row_ready) begin
			if (predicted_rows.size() == 0) begin
				errors++;
				$display("%0t: no row expected, actual %p", $time, row_data);
			end else begin
				want_row = predicted_rows.pop_front();
				check_field("u_row", want_row.u_row, row_data.u_row);
				check_field("v_row", want_row.v_row, row_data.v_row);
				check_field("row_index", 64'(want_row.row_index), 64'(row_data.row_index));
				check_field("last_row", 64'(want_row.last_row), 64'(row_data.last_row));
				rows_checked++;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (row_valid && row_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: watchdog expired, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		cip8_pkg::req_t rq;
		logic [63:0] ones;
		logic [63:0] half;
		ones = {8{8'hFF}};
		half = 64'h00000000_01010101;

		// DC with every availability combination, including exact half rounding.
		add_block(make_req(cip8_pkg::MODE_DC, 1'b0, 1'b0, rand_samples(), rand_samples(),
				rand_samples(), rand_samples(), 8'h00, 8'hFF), 1'b0);
		add_block(make_req(cip8_pkg::MODE_DC, 1'b1, 1'b0, ones, ones, '0, '0, 8'hFF, 8'h00),
				1'b0);
		add_block(make_req(cip8_pkg::MODE_DC, 1'b0, 1'b1, '0, '0, half, half, 8'h00, 8'h00),
				1'b0);
		add_block(make_req(cip8_pkg::MODE_DC, 1'b1, 1'b0, half, half, ones, ones, 8'h00, 8'h00),
				1'b0);
		add_block(make_req(cip8_pkg::MODE_DC, 1'b1, 1'b1, ones, ones, ones, ones, 8'hFF, 8'hFF),
				1'b0);
		add_block(make_req(cip8_pkg::MODE_DC, 1'b1, 1'b1, half, '0, half, '0, 8'h00, 8'h00),
				1'b0);
		add_block(make_req(cip8_pkg::MODE_DC, 1'b1, 1'b1, '0, '0, '0, '0, 8'h00, 8'h00), 1'b0);
		add_block(make_req(cip8_pkg::MODE_DC, 1'b1, 1'b1, rand_samples(), rand_samples(),
				rand_samples(), rand_samples(), 8'h55, 8'hAA), 1'b0);
		// Vertical, horizontal and TrueMotion must ignore the availability flags.
		add_block(make_req(cip8_pkg::MODE_VERT, 1'b0, 1'b0, ones, '0, '0, ones, 8'h00, 8'hFF),
				1'b0);
		add_block(make_req(cip8_pkg::MODE_VERT, 1'b1, 1'b1, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 8'h12, 8'h34),
				1'b0);
		add_block(make_req(cip8_pkg::MODE_HORZ, 1'b0, 1'b0, '0, ones, 64'h0706050403020100,
				64'hF8F9FAFBFCFDFEFF, 8'hFF, 8'h00), 1'b0);
		add_block(make_req(cip8_pkg::MODE_HORZ, 1'b1, 1'b0, ones, ones, ones, '0, 8'h80, 8'h80),
				1'b0);
		// TrueMotion clamped at both ends, then unclamped.
		add_block(make_req(cip8_pkg::MODE_TM, 1'b0, 1'b0, '0, '0, '0, '0, 8'hFF, 8'hFF), 1'b0);
		add_block(make_req(cip8_pkg::MODE_TM, 1'b0, 1'b1, ones, ones, ones, ones, 8'h00, 8'h00),
				1'b0);
		add_block(make_req(cip8_pkg::MODE_TM, 1'b1, 1'b0, 64'h80808080_80808080,
				64'h00FF00FF_00FF00FF, 64'h0102040810204080, 64'hFF7F3F1F0F070301, 8'h80, 8'h7F),
				1'b0);
		add_block(make_req(cip8_pkg::MODE_TM, 1'b1, 1'b1, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom),
				8'($urandom)), 1'b0);

		for (int n = 0; n < RANDOM_BLOCKS; n++) begin
			rq = make_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), rand_samples(), rand_samples(), rand_samples(),
					rand_samples(), rand_sample(), rand_sample());
			// Now and then the sender holds back until every predicted row has come out.
			add_block(rq, (n % 70) == 0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (blocks_accepted == total_blocks);
		wait (predicted_rows.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d blocks: DC %0d, vertical %0d, horizontal %0d, TrueMotion %0d.",
				blocks_accepted, mode_hits[cip8_pkg::MODE_DC], mode_hits[cip8_pkg::MODE_VERT],
				mode_hits[cip8_pkg::MODE_HORZ], mode_hits[cip8_pkg::MODE_TM]);
		$display("Checked %0d rows under random stalls on both sides; %0d errors.",
				rows_checked, errors);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/cip8_pkg.sv
hw/rtl/cip8_front.sv
hw/rtl/cip8_queue.sv
hw/rtl/cip8_back.sv
hw/rtl/chroma_intra_predictor_8x8.sv
dv/chroma_intra_predictor_8x8_tb.sv
